### design/ir_heatpump_frame_transmitter_macros.svh
// ----------------------------------------------------------------------------
// IR heat-pump frame transmitter: assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IR_HEATPUMP_FRAME_TRANSMITTER_MACROS_SVH
`define IR_HEATPUMP_FRAME_TRANSMITTER_MACROS_SVH

// Plain property, checked every clock outside reset
`define IRHP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication in the same cycle
`define IRHP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle
`define IRHP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/irhp_pkg.sv
// ----------------------------------------------------------------------------
// IR heat-pump frame transmitter: package
// Frame phases, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package irhp_pkg;

  // Default message length in bits
  localparam int unsigned MessageBitsDefault = 64;

  // Field widths
  localparam int unsigned DurW      = 15;
  localparam int unsigned MsgW      = 64;
  localparam int unsigned MsgBitsW  = 7;
  localparam int unsigned RepeatW   = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumRegs   = 6;
  localparam int unsigned InDataW   = 88;
  localparam int unsigned OutDataW  = 8;

  // Footer bits sent between halves, indexed by 2 - position
  localparam logic [3:0] FooterBits = 4'b0010;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_GAP_SPACE    = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam logic [DurW-1:0] HeaderMarkReset  = 15'd9000;
  localparam logic [DurW-1:0] HeaderSpaceReset = 15'd4000;
  localparam logic [DurW-1:0] BitMarkReset     = 15'd620;
  localparam logic [DurW-1:0] OneSpaceReset    = 15'd1600;
  localparam logic [DurW-1:0] ZeroSpaceReset   = 15'd540;
  localparam logic [DurW-1:0] GapSpaceReset    = 15'd19000;

  // Frame phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_DATA    = 3'd2,
    PH_MIDBITS = 3'd3,
    PH_MIDGAP  = 3'd4,
    PH_ENDGAP  = 3'd5
  } phase_e;

  // Result word fields
  typedef struct packed {
    logic rejected;
    logic busy_res;
    logic ir_active;
  } result_t;

  // Segment length: a zero duration still lasts one tick
  function automatic logic [DurW-1:0] seg_len(input logic [DurW-1:0] ticks);
    seg_len = (ticks == '0) ? DurW'(1) : ticks;
  endfunction

endpackage

### design/ir_heatpump_frame_transmitter.sv
// ----------------------------------------------------------------------------
// IR heat-pump frame transmitter
// Steps an infrared mark/space envelope one tick per input word and reports
// the level, busy and reject flags for every word.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                Contents
//  s_axis    in   tvalid/tready            tuser: command; tdata: message, bits, repeats
//  m_axis    out  tvalid/tready            tdata: ir_active, busy_res, rejected
//  cfg       in   cfg_we_i (no wait)       cfg_idx_i selects one of six duration registers
//
//  One word per cycle while the skid register is empty: each accepted word is decoded
//  against the frame state and its result lands in the output or skid register.
//  A one-entry skid register behind the output keeps s_axis_tready registered;
//  input is held off only while the skid register is full.
//  Reset clears the frame state, loads the duration registers with their
//  defaults and empties both output stages.
//
`include "ir_heatpump_frame_transmitter_macros.svh"

module ir_heatpump_frame_transmitter #(
  parameter int unsigned MESSAGE_BITS = irhp_pkg::MessageBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [63:0] message, [70:64] message_bits, [86:71] repeat_count, [87] zero
  input  logic [irhp_pkg::InDataW-1:0] s_axis_tdata,
  // [0] command
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] ir_active, [1] busy_res, [2] rejected, [7:3] zero
  output logic [irhp_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [irhp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irhp_pkg::DurW-1:0]    cfg_wdata_i
);

  localparam int unsigned NBytes    = MESSAGE_BITS / 8;
  localparam int unsigned HalfBits  = MESSAGE_BITS / 2;
  localparam int unsigned BpW       = $clog2(MESSAGE_BITS + 1);
  localparam int unsigned ShW       = $clog2(MESSAGE_BITS);
  localparam bit          MidOnByte = (HalfBits % 8) == 0;
  localparam logic [BpW-1:0] HalfPos  = BpW'(HalfBits);
  localparam logic [BpW-1:0] EndPos   = BpW'(NBytes * 8);
  localparam logic [BpW-1:0] ShiftBase = BpW'(MESSAGE_BITS - 8);
  localparam logic [irhp_pkg::MsgBitsW-1:0] ExpBits = irhp_pkg::MsgBitsW'(MESSAGE_BITS);

  // Input word unpacking
  logic                             cmd_start;
  logic [irhp_pkg::MsgW-1:0]        in_message;
  logic [irhp_pkg::MsgBitsW-1:0]    in_msg_bits;
  logic [irhp_pkg::RepeatW-1:0]     in_repeat;

  assign cmd_start   = s_axis_tuser;
  assign in_message  = s_axis_tdata[63:0];
  assign in_msg_bits = s_axis_tdata[70:64];
  assign in_repeat   = s_axis_tdata[86:71];

  // Duration registers
  logic [irhp_pkg::DurW-1:0] cfg_q [irhp_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[irhp_pkg::REG_HEADER_MARK]  <= irhp_pkg::HeaderMarkReset;
      cfg_q[irhp_pkg::REG_HEADER_SPACE] <= irhp_pkg::HeaderSpaceReset;
      cfg_q[irhp_pkg::REG_BIT_MARK]     <= irhp_pkg::BitMarkReset;
      cfg_q[irhp_pkg::REG_ONE_SPACE]    <= irhp_pkg::OneSpaceReset;
      cfg_q[irhp_pkg::REG_ZERO_SPACE]   <= irhp_pkg::ZeroSpaceReset;
      cfg_q[irhp_pkg::REG_GAP_SPACE]    <= irhp_pkg::GapSpaceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irhp_pkg::REG_HEADER_MARK:  cfg_q[irhp_pkg::REG_HEADER_MARK]  <= cfg_wdata_i;
        irhp_pkg::REG_HEADER_SPACE: cfg_q[irhp_pkg::REG_HEADER_SPACE] <= cfg_wdata_i;
        irhp_pkg::REG_BIT_MARK:     cfg_q[irhp_pkg::REG_BIT_MARK]     <= cfg_wdata_i;
        irhp_pkg::REG_ONE_SPACE:    cfg_q[irhp_pkg::REG_ONE_SPACE]    <= cfg_wdata_i;
        irhp_pkg::REG_ZERO_SPACE:   cfg_q[irhp_pkg::REG_ZERO_SPACE]   <= cfg_wdata_i;
        irhp_pkg::REG_GAP_SPACE:    cfg_q[irhp_pkg::REG_GAP_SPACE]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame state
  irhp_pkg::phase_e            phase_q, phase_d;
  logic [MESSAGE_BITS-1:0]     msg_q, msg_d;
  logic [irhp_pkg::RepeatW-1:0] rep_q, rep_d;
  logic [BpW-1:0]              bp_q, bp_d;
  logic [irhp_pkg::DurW-1:0]   dur_q, dur_d;
  logic                        mark_q, mark_d;

  // Output and skid stages
  logic                        out_valid_q, skid_valid_q;
  irhp_pkg::result_t           out_q, skid_q, res;

  logic accept;
  logic busy;
  logic [BpW-1:0] bp_inc;
  logic [BpW-1:0] shift_full;
  logic           data_bit;
  logic [1:0]     foot_sel;
  logic           foot_bit;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign busy          = phase_q != irhp_pkg::PH_IDLE;
  assign bp_inc        = bp_q + BpW'(1);

  // Pick the data bit: bytes top first, each byte LSB first
  assign shift_full = ShiftBase - {bp_q[BpW-1:3], 3'b000} + BpW'(bp_q[2:0]);
  assign data_bit   = msg_q[shift_full[ShW-1:0]];

  // Footer bit for the current footer position
  assign foot_sel = 2'd2 - bp_q[1:0];
  assign foot_bit = irhp_pkg::FooterBits[foot_sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= irhp_pkg::PH_IDLE;
      msg_q   <= '0;
      rep_q   <= '0;
      bp_q    <= '0;
      dur_q   <= '0;
      mark_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      msg_q   <= msg_d;
      rep_q   <= rep_d;
      bp_q    <= bp_d;
      dur_q   <= dur_d;
      mark_q  <= mark_d;
    end
  end

  // Next frame state and result for the accepted word
  always_comb begin
    phase_d = phase_q;
    msg_d   = msg_q;
    rep_d   = rep_q;
    bp_d    = bp_q;
    dur_d   = dur_q;
    mark_d  = mark_q;
    res     = '0;
    if (accept) begin
      if (cmd_start) begin
        if (busy || in_msg_bits != ExpBits) begin
          // refuse: state holds
          res.rejected  = 1'b1;
          res.busy_res  = busy;
          res.ir_active = busy && mark_q;
        end else begin
          msg_d   = in_message[MESSAGE_BITS-1:0];
          rep_d   = in_repeat;
          bp_d    = '0;
          phase_d = irhp_pkg::PH_HEADER;
          mark_d  = 1'b1;
          dur_d   = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_HEADER_MARK]);
          res.busy_res  = 1'b1;
          res.ir_active = 1'b1;
        end
      end else if (busy) begin
        res.busy_res  = 1'b1;
        res.ir_active = mark_q;
        if (dur_q > irhp_pkg::DurW'(1)) begin
          dur_d = dur_q - irhp_pkg::DurW'(1);
        end else begin
          // advance to the next segment
          unique case (phase_q)
            irhp_pkg::PH_HEADER: begin
              if (mark_q) begin
                mark_d = 1'b0;
                dur_d  = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_HEADER_SPACE]);
              end else begin
                bp_d    = '0;
                phase_d = irhp_pkg::PH_DATA;
                mark_d  = 1'b1;
                dur_d   = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_BIT_MARK]);
              end
            end
            irhp_pkg::PH_DATA: begin
              if (mark_q) begin
                mark_d = 1'b0;
                dur_d  = irhp_pkg::seg_len(data_bit ? cfg_q[irhp_pkg::REG_ONE_SPACE]
                                                    : cfg_q[irhp_pkg::REG_ZERO_SPACE]);
              end else begin
                mark_d = 1'b1;
                dur_d  = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_BIT_MARK]);
                if (MidOnByte && bp_inc == HalfPos) begin
                  bp_d    = '0;
                  phase_d = irhp_pkg::PH_MIDBITS;
                end else if (bp_inc >= EndPos) begin
                  bp_d    = bp_inc;
                  phase_d = irhp_pkg::PH_ENDGAP;
                end else begin
                  bp_d = bp_inc;
                end
              end
            end
            irhp_pkg::PH_MIDBITS: begin
              if (mark_q) begin
                mark_d = 1'b0;
                dur_d  = irhp_pkg::seg_len(foot_bit ? cfg_q[irhp_pkg::REG_ONE_SPACE]
                                                    : cfg_q[irhp_pkg::REG_ZERO_SPACE]);
              end else begin
                bp_d   = bp_inc;
                mark_d = 1'b1;
                dur_d  = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_BIT_MARK]);
                if (bp_inc >= BpW'(3)) begin
                  phase_d = irhp_pkg::PH_MIDGAP;
                end
              end
            end
            irhp_pkg::PH_MIDGAP: begin
              if (mark_q) begin
                mark_d = 1'b0;
                dur_d  = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_GAP_SPACE]);
              end else begin
                bp_d    = HalfPos;
                phase_d = irhp_pkg::PH_DATA;
                mark_d  = 1'b1;
                dur_d   = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_BIT_MARK]);
              end
            end
            irhp_pkg::PH_ENDGAP: begin
              if (mark_q) begin
                mark_d = 1'b0;
                dur_d  = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_GAP_SPACE]);
              end else if (rep_q != '0) begin
                // repeat the frame
                rep_d   = rep_q - irhp_pkg::RepeatW'(1);
                phase_d = irhp_pkg::PH_HEADER;
                mark_d  = 1'b1;
                dur_d   = irhp_pkg::seg_len(cfg_q[irhp_pkg::REG_HEADER_MARK]);
              end else begin
                phase_d = irhp_pkg::PH_IDLE;
                mark_d  = 1'b0;
                dur_d   = '0;
                bp_d    = '0;
              end
            end
            default: begin
              phase_d = irhp_pkg::PH_IDLE;
              mark_d  = 1'b0;
              dur_d   = '0;
            end
          endcase
        end
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: drain skid first, else take the new result
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_valid_q || m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || m_axis_tready) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(irhp_pkg::OutDataW - 3){1'b0}}, out_q};

  // Checks
  `IRHP_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `IRHP_ASSERT(a_idle_no_count, (phase_q != irhp_pkg::PH_IDLE) == (dur_q != '0),
               "segment count out of step with phase")
  `IRHP_ASSERT_NEXT(a_tick_counts_down,
                    accept && !cmd_start && busy && dur_q > irhp_pkg::DurW'(1),
                    dur_q == $past(dur_q) - irhp_pkg::DurW'(1) && phase_q == $past(phase_q),
                    "tick inside a segment did not count down")

endmodule
